// File: rtl/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg
// Types, command codes and constants shared by the clock command coprocessor.
// ----------------------------------------------------------------------------
package ccc_pkg;

   // Password length, which is also the size of the flop window at the
   // bottom of the stack.
   localparam int PW_LEN        = 16;
   // Stack address that the pointer command jumps to.
   localparam int CONVERTER_PTR = 32;

   // Item kinds.
   localparam logic ITEM_CMD  = 1'b0;
   localparam logic ITEM_TICK = 1'b1;

   // Operation nibble.
   localparam logic [3:0] OPC_PUSH_FROM_BASE = 4'h0;
   localparam logic [3:0] OPC_REQUEST        = 4'h5;
   localparam logic [3:0] OPC_ACTION         = 4'h6;
   localparam logic [3:0] OPC_PUSH           = 4'h7;
   localparam logic [3:0] OPC_POINTER        = 4'hC;

   // Argument of the pointer command.
   localparam logic [3:0] ARG_ADIN = 4'h3;

   // Request arguments.
   localparam logic [3:0] REQ_STATUS_A    = 4'h1;
   localparam logic [3:0] REQ_STATUS_B    = 4'h3;
   localparam logic [3:0] REQ_AUX_BATTERY = 4'h5;
   localparam logic [3:0] REQ_ANALOG      = 4'h6;
   localparam logic [3:0] REQ_MAIN_SUPPLY = 4'h7;
   localparam logic [3:0] REQ_ID          = 4'hA;
   localparam logic [3:0] REQ_STATUS      = 4'hC;
   localparam logic [3:0] REQ_INT_CAUSE   = 4'hD;
   localparam logic [3:0] REQ_MASK_READ   = 4'hE;
   localparam logic [3:0] REQ_MASK_WRITE  = 4'hF;

   // Action arguments.
   localparam logic [3:0] ACT_PW_CLEAR   = 4'h4;
   localparam logic [3:0] ACT_PW_SET     = 4'h5;
   localparam logic [3:0] ACT_TIME_READ  = 4'hC;
   localparam logic [3:0] ACT_TIME_WRITE = 4'hD;
   localparam logic [3:0] ACT_POP        = 4'hF;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAIN_SUPPLY = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUX_BATTERY = 4'd1;

   // Fixed reply values and calendar limits.
   localparam logic [7:0] LEVEL_RESET     = 8'd192;
   localparam logic [7:0] REPLY_ID        = 8'hA0;
   localparam logic [7:0] STATUS_BASE     = 8'h20;
   localparam logic [7:0] STATUS_PW_FLAG  = 8'h04;
   localparam logic [7:0] SKIP_MARK       = 8'h0F;
   localparam logic [7:0] SEC_LIMIT       = 8'h60;
   localparam logic [7:0] HOUR_LIMIT      = 8'h24;
   localparam logic [7:0] LONG_MONTH_END  = 8'h32;
   localparam logic [7:0] SHORT_MONTH_END = 8'h31;
   localparam logic [7:0] MONTH_WRAP      = 8'd13;
   localparam logic [7:0] DAY_FIRST       = 8'h01;
   localparam logic [7:0] MONTH_FIRST     = 8'd1;
   localparam logic [2:0] WEEKDAY_LAST    = 3'd6;

   typedef logic [PW_LEN-1:0][7:0] window_type;

   typedef struct packed {
      logic       op;
      logic [7:0] cmd_byte;
      logic [7:0] analog_value;
   } req_payload_type;

   typedef struct packed {
      logic       reply_valid;
      logic [7:0] reply_byte;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] sec;
      logic [7:0] min;
      logic [7:0] hour;
      logic [7:0] day;
      logic [7:0] month;
      logic [2:0] weekday;
   } calendar_type;

   typedef struct packed {
      logic       clear_ptr;
      logic       push;
      logic [7:0] push_data;
      logic       set_adin;
      logic       snapshot;
      logic       pop;
   } stack_cmd_type;

   typedef struct packed {
      logic tick;
      logic load;
   } calendar_cmd_type;

   typedef struct packed {
      logic       wrap;
      logic [7:0] value;
   } bcd_step_type;

   // Increment a BCD pair; a units digit reaching ten carries into the tens.
   function automatic logic [7:0] bcd_digit_inc(input logic [7:0] v);
      logic [7:0] x;
      x = v + 8'd1;
      if (x[3:0] >= 4'd10) begin
         x = {x[7:4] + 4'd1, 4'h0};
      end
      return x;
   endfunction

   // Seconds and minutes step: the limit is checked only on a tens carry.
   function automatic bcd_step_type bcd_inc(input logic [7:0] v, input logic [7:0] limit);
      logic [7:0]   x;
      bcd_step_type r;
      x       = v + 8'd1;
      r.wrap  = 1'b0;
      r.value = x;
      if (x[3:0] >= 4'd10) begin
         x = {x[7:4] + 4'd1, 4'h0};
         if (x < limit) begin
            r.value = x;
         end else begin
            r.value = 8'h00;
            r.wrap  = 1'b1;
         end
      end
      return r;
   endfunction

   // Day value at which the month rolls over; zero means it never does.
   function automatic logic [7:0] month_end(input logic [7:0] month);
      logic [7:0] limit;
      limit = 8'h00;
      if (month inside {8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12}) begin
         limit = LONG_MONTH_END;
      end else if (month inside {8'd2, 8'd4, 8'd6, 8'd9, 8'd11}) begin
         limit = SHORT_MONTH_END;
      end
      return limit;
   endfunction

endpackage

// File: rtl/ccc_calendar.sv
// ----------------------------------------------------------------------------
// ccc_calendar
// BCD calendar clock: one-second advance and load from the stack window.
// ----------------------------------------------------------------------------
module ccc_calendar (
   input  logic                       clock,
   input  logic                       reset,
   input  ccc_pkg::calendar_cmd_type  cal_cmd,
   input  ccc_pkg::window_type        stack_low,
   output ccc_pkg::calendar_type      cal
);
   import ccc_pkg::*;

   calendar_type cal_ff, cal_in;
   bcd_step_type sec_step, min_step;
   logic [7:0]   hour_next, day_next, day_limit;
   logic [2:0]   weekday_next;

   always_comb begin
      cal_in       = cal_ff;
      sec_step     = bcd_inc(cal_ff.sec, SEC_LIMIT);
      min_step     = bcd_inc(cal_ff.min, SEC_LIMIT);
      hour_next    = bcd_digit_inc(cal_ff.hour);
      day_next     = bcd_digit_inc(cal_ff.day);
      day_limit    = month_end(cal_ff.month);
      weekday_next = (cal_ff.weekday >= WEEKDAY_LAST) ? 3'd0 : cal_ff.weekday + 3'd1;

      if (cal_cmd.tick) begin
         cal_in.sec = sec_step.value;
         if (sec_step.wrap) begin
            cal_in.min = min_step.value;
            if (min_step.wrap) begin
               if (hour_next >= HOUR_LIMIT) begin
                  cal_in.hour    = 8'h00;
                  cal_in.day     = day_next;
                  cal_in.weekday = weekday_next;
                  if (day_limit != 8'h00 && day_next == day_limit) begin
                     cal_in.day   = DAY_FIRST;
                     cal_in.month = (cal_ff.month + 8'd1 == MONTH_WRAP) ?
                                    MONTH_FIRST : cal_ff.month + 8'd1;
                  end
               end else begin
                  cal_in.hour = hour_next;
               end
            end
         end
      end else if (cal_cmd.load) begin
         // A pair is loaded only when neither digit holds the skip mark.
         if (stack_low[0] != SKIP_MARK) begin
            cal_in.month = stack_low[0];
         end
         if (stack_low[1] != SKIP_MARK && stack_low[2] != SKIP_MARK) begin
            cal_in.day = {stack_low[1][3:0], stack_low[2][3:0]};
         end
         if (stack_low[3] != SKIP_MARK && stack_low[4] != SKIP_MARK) begin
            cal_in.hour = {stack_low[3][3:0], stack_low[4][3:0]};
         end
         if (stack_low[5] != SKIP_MARK && stack_low[6] != SKIP_MARK) begin
            cal_in.min = {stack_low[5][3:0], stack_low[6][3:0]};
         end
         if (stack_low[7] != SKIP_MARK && stack_low[8] != SKIP_MARK) begin
            cal_in.sec = {stack_low[7][3:0], stack_low[8][3:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff.sec     <= 8'h00;
         cal_ff.min     <= 8'h00;
         cal_ff.hour    <= 8'h00;
         cal_ff.day     <= DAY_FIRST;
         cal_ff.month   <= MONTH_FIRST;
         cal_ff.weekday <= 3'd0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   assign cal = cal_ff;

endmodule

// File: rtl/ccc_stack.sv
// ----------------------------------------------------------------------------
// ccc_stack
// Byte stack: a flop window for the bottom entries, a memory above it,
// and the stack pointer.
// ----------------------------------------------------------------------------
module ccc_stack #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ccc_pkg::stack_cmd_type  stack_cmd,
   input  ccc_pkg::calendar_type   cal,
   output ccc_pkg::window_type     stack_low,
   output logic [7:0]              top_byte
);
   import ccc_pkg::*;

   localparam int PTR_W = $clog2(STACK_DEPTH);
   localparam int LOW_W = $clog2(PW_LEN);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(STACK_DEPTH - 1);
   localparam logic [PTR_W-1:0] ADIN_PTR = PTR_W'(CONVERTER_PTR % STACK_DEPTH);
   localparam logic [PTR_W-1:0] LOW_END  = PTR_W'(PW_LEN);

   logic [PTR_W-1:0]          ptr_ff, ptr_in, base, base_inc;
   window_type                low_ff, low_in;
   logic [7:0]                mem [PW_LEN:STACK_DEPTH-1];
   logic [STACK_DEPTH-1:PW_LEN] mem_vld_ff;
   logic [7:0]                rd_data_ff;
   logic                      mem_we;

   always_comb begin
      base     = stack_cmd.clear_ptr ? '0 : ptr_ff;
      base_inc = (base == LAST_PTR) ? '0 : base + 1'b1;
      ptr_in   = ptr_ff;
      low_in   = low_ff;
      mem_we   = 1'b0;
      if (stack_cmd.push) begin
         ptr_in = base_inc;
         if (base < LOW_END) begin
            low_in[base[LOW_W-1:0]] = stack_cmd.push_data;
         end else begin
            mem_we = 1'b1;
         end
      end else if (stack_cmd.set_adin) begin
         ptr_in = ADIN_PTR;
      end else if (stack_cmd.snapshot) begin
         low_in[0] = cal.month;
         low_in[1] = {4'h0, cal.day[7:4]};
         low_in[2] = {4'h0, cal.day[3:0]};
         low_in[3] = {4'h0, cal.hour[7:4]};
         low_in[4] = {4'h0, cal.hour[3:0]};
         low_in[5] = {4'h0, cal.min[7:4]};
         low_in[6] = {4'h0, cal.min[3:0]};
         low_in[7] = {4'h0, cal.sec[7:4]};
         low_in[8] = {4'h0, cal.sec[3:0]};
         ptr_in    = '0;
      end else if (stack_cmd.pop) begin
         ptr_in = (ptr_ff == LAST_PTR) ? '0 : ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         low_ff     <= '0;
         mem_vld_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
         low_ff <= low_in;
         if (mem_we) begin
            mem_vld_ff[base] <= 1'b1;
         end
      end
   end

   // The read runs at the pointer's next value whenever that lies above the
   // flop window, so the data for the entry under the pointer is always waiting.
   // A push never writes the entry that the pointer moves to.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[base] <= stack_cmd.push_data;
      end
      if (ptr_in >= LOW_END) begin
         rd_data_ff <= mem[ptr_in];
      end
   end

   assign stack_low = low_ff;
   assign top_byte  = (ptr_ff < LOW_END) ? low_ff[ptr_ff[LOW_W-1:0]] :
                      (mem_vld_ff[ptr_ff] ? rd_data_ff : 8'h00);

endmodule

// File: rtl/clock_command_coprocessor.sv
// ----------------------------------------------------------------------------
// clock_command_coprocessor
// Clock coprocessor that executes command bytes and one-second ticks
// against a byte stack, a BCD calendar, a password and an interrupt mask.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Beat contents                  Accepted when
//   req_     in         op, cmd_byte, analog_value     req_valid & req_ready
//   rsp_     out        reply_valid, reply_byte        rsp_valid & rsp_ready
//   csr_     in         csr_index, csr_data            csr_valid & csr_ready
//
// A request beat is captured in the input register and executed once the
// output register is free, when its result beat is loaded into that register;
// every request beat produces exactly one result beat.
// Throughput is one beat per cycle while the result side does not stall; the
// input register takes a new beat in the same cycle the held one executes.
// Pop data comes from the flop window or the stack memory's registered read
// port, read at the next pointer value whenever that lies above the window.
// Reset is synchronous and active high; all state is usable the cycle after.
// A stalled result beat holds the held request, and the input register
// holds back req_ready once it is occupied and cannot drain.
// ----------------------------------------------------------------------------
module clock_command_coprocessor #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ccc_pkg::req_payload_type         req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ccc_pkg::rsp_payload_type         rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ccc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                       csr_data
);
   import ccc_pkg::*;

   // Input register.
   logic            in_vld_ff;
   req_payload_type in_data_ff;
   logic            exec_fire;

   // Configuration registers.
   logic [7:0] main_supply_ff, aux_battery_ff;

   // Architectural state kept at this level.
   window_type pw_ff, pw_in;
   logic [7:0] mask_ff, mask_in;
   logic [7:0] last_reply_ff, last_reply_in;
   logic       reply_flag_ff, reply_flag_in;
   logic       rsp_valid_ff;

   // Command decode.
   logic [3:0]       opcode, arg;
   stack_cmd_type    stack_cmd;
   calendar_cmd_type cal_cmd;
   calendar_type     cal;
   window_type       stack_low;
   logic [7:0]       top_byte;

   // The held command executes when the output register is empty or is
   // being emptied in this cycle.
   assign exec_fire = in_vld_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_vld_ff || exec_fire;
   assign csr_ready = 1'b1;

   assign opcode = in_data_ff.cmd_byte[7:4];
   assign arg    = in_data_ff.cmd_byte[3:0];

   always_comb begin
      stack_cmd           = '0;
      stack_cmd.push_data = {4'h0, ~arg};
      cal_cmd             = '0;
      pw_in               = pw_ff;
      mask_in             = mask_ff;
      last_reply_in       = last_reply_ff;
      reply_flag_in       = 1'b0;
      if (exec_fire) begin
         if (in_data_ff.op == ITEM_TICK) begin
            cal_cmd.tick = 1'b1;
         end else begin
            case (opcode)
               OPC_PUSH_FROM_BASE: begin
                  stack_cmd.clear_ptr = 1'b1;
                  stack_cmd.push      = 1'b1;
               end
               OPC_PUSH: begin
                  stack_cmd.push = 1'b1;
               end
               OPC_POINTER: begin
                  stack_cmd.set_adin = (arg == ARG_ADIN);
               end
               OPC_REQUEST: begin
                  // Every request replies; an unknown one repeats the last byte.
                  reply_flag_in = 1'b1;
                  case (arg)
                     REQ_STATUS_A, REQ_STATUS_B, REQ_INT_CAUSE: begin
                        last_reply_in = 8'h00;
                     end
                     REQ_AUX_BATTERY: begin
                        last_reply_in = aux_battery_ff;
                     end
                     REQ_ANALOG: begin
                        last_reply_in = in_data_ff.analog_value;
                     end
                     REQ_MAIN_SUPPLY: begin
                        last_reply_in = main_supply_ff;
                     end
                     REQ_ID: begin
                        last_reply_in = REPLY_ID;
                     end
                     REQ_STATUS: begin
                        last_reply_in = STATUS_BASE |
                                        ((pw_ff[0] != 8'h00) ? STATUS_PW_FLAG : 8'h00);
                     end
                     REQ_MASK_READ: begin
                        last_reply_in = mask_ff;
                     end
                     REQ_MASK_WRITE: begin
                        mask_in = {stack_low[0][3:0], 4'h0} + stack_low[1];
                     end
                     default: begin
                     end
                  endcase
               end
               OPC_ACTION: begin
                  case (arg)
                     ACT_PW_CLEAR: begin
                        if (pw_ff == stack_low) begin
                           pw_in[0] = 8'h00;
                        end
                     end
                     ACT_PW_SET: begin
                        pw_in = stack_low;
                     end
                     ACT_TIME_READ: begin
                        stack_cmd.snapshot = 1'b1;
                     end
                     ACT_TIME_WRITE: begin
                        cal_cmd.load = 1'b1;
                     end
                     ACT_POP: begin
                        stack_cmd.pop = 1'b1;
                        last_reply_in = top_byte;
                        reply_flag_in = 1'b1;
                     end
                     default: begin
                     end
                  endcase
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         reply_flag_ff  <= 1'b0;
         last_reply_ff  <= 8'h00;
         mask_ff        <= 8'h00;
         pw_ff          <= '0;
         main_supply_ff <= LEVEL_RESET;
         aux_battery_ff <= LEVEL_RESET;
      end else begin
         if (req_ready) begin
            in_vld_ff <= req_valid;
         end
         if (exec_fire) begin
            rsp_valid_ff  <= 1'b1;
            reply_flag_ff <= reply_flag_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         last_reply_ff <= last_reply_in;
         mask_ff       <= mask_in;
         pw_ff         <= pw_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_MAIN_SUPPLY: main_supply_ff <= csr_data;
               CSR_AUX_BATTERY: aux_battery_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   ccc_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .stack_cmd (stack_cmd),
      .cal       (cal),
      .stack_low (stack_low),
      .top_byte  (top_byte)
   );

   ccc_calendar u_calendar (
      .clock     (clock),
      .reset     (reset),
      .cal_cmd   (cal_cmd),
      .stack_low (stack_low),
      .cal       (cal)
   );

   // The reply byte register always holds the last reply, which is exactly
   // what a beat without a new reply reports.
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.reply_valid  = reply_flag_ff;
   assign rsp_data.reply_byte   = last_reply_ff;

endmodule

// File: rtl/ccc_checker.sv
// ----------------------------------------------------------------------------
// ccc_checker
// Port-level checks for the clock command coprocessor, bound to the top.
// ----------------------------------------------------------------------------
module ccc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input ccc_pkg::rsp_payload_type  rsp_data
);
   import ccc_pkg::*;

   logic [1:0] occ_ff;
   logic [7:0] seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= 2'd0;
         seen_ff <= 8'h00;
      end else begin
         occ_ff <= occ_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
         if (rsp_valid && rsp_ready) begin
            seen_ff <= rsp_data.reply_byte;
         end
      end
   end

   // A result beat only appears for a command still in flight.
   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> occ_ff != 2'd0)
      else $error("result beat with no command in flight");

   // The input and output registers hold at most two commands.
   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff != 2'd3)
      else $error("more than two commands in flight");

   // A stalled result beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // A beat without a new reply repeats the byte delivered before it.
   a_reply_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.reply_valid |-> rsp_data.reply_byte == seen_ff)
      else $error("reply byte changed without a reply");

endmodule

bind clock_command_coprocessor ccc_checker u_ccc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the clock command coprocessor. A directed table
// covers the fixed replies, the ignored commands, the pointer jump and a
// first round trip through the stack, the calendar and the password. Random
// command sequences then load times close to their wraps, run ticks across
// them, set and clear the password, write the mask and walk the stack
// pointer around its wrap. Every accepted request beat is run through a
// local model of the block, and every result beat is checked against the
// oldest expectation.
// ----------------------------------------------------------------------------
module testbench;
   import ccc_pkg::*;

   localparam int DEPTH       = 64;
   localparam int CYCLE_LIMIT = 100_000;
   localparam int MAX_REPORTS = 10;

   // Opcode that the block does not decode; used to show it is ignored.
   localparam logic [3:0] OPC_UNUSED = 4'h1;

   // A table row either carries its reply written out or leaves it to the
   // model of the block.
   localparam bit TYPED     = 1'b1;
   localparam bit PREDICTED = 1'b0;

   typedef struct packed {
      req_payload_type beat;
      bit              typed;
      rsp_payload_type reply;
   } directed_row_type;

   // The table starts right after reset, so both supply levels still hold
   // their reset value.
   localparam directed_row_type DIRECTED [25] = '{
      '{'{ITEM_CMD, {OPC_REQUEST, REQ_AUX_BATTERY}, 8'h00}, TYPED, '{1'b1, LEVEL_RESET}},
      '{'{ITEM_CMD, {OPC_REQUEST, REQ_MAIN_SUPPLY}, 8'h00}, TYPED, '{1'b1, LEVEL_RESET}},
      '{'{ITEM_CMD, {OPC_REQUEST, REQ_ANALOG},      8'hFF}, TYPED, '{1'b1, 8'hFF}},
      '{'{ITEM_CMD, {OPC_REQUEST, REQ_ID},          8'h00}, TYPED, '{1'b1, REPLY_ID}},
      '{'{ITEM_CMD, {OPC_REQUEST, REQ_INT_CAUSE},   8'hFF}, TYPED, '{1'b1, 8'h00}},
      '{'{ITEM_CMD, {OPC_REQUEST, REQ_ID},          8'h00}, TYPED, '{1'b1, REPLY_ID}},
      '{'{ITEM_CMD, {OPC_REQUEST, REQ_STATUS_A},    8'h00}, TYPED, '{1'b1, 8'h00}},
      '{'{ITEM_CMD, {OPC_REQUEST, REQ_STATUS},      8'h00}, TYPED, '{1'b1, STATUS_BASE}},
      '{'{ITEM_CMD, {OPC_REQUEST, REQ_STATUS_B},    8'h00}, TYPED, '{1'b1, 8'h00}},
      '{'{ITEM_CMD, {OPC_REQUEST, REQ_MASK_READ},   8'h00}, TYPED, '{1'b1, 8'h00}},
      '{'{ITEM_CMD, {OPC_PUSH_FROM_BASE, 4'h0},     8'h00}, TYPED, '{1'b0, 8'h00}},
      '{'{ITEM_CMD, {OPC_PUSH, 4'hF},               8'h00}, TYPED, '{1'b0, 8'h00}},
      '{'{ITEM_CMD, {OPC_REQUEST, REQ_MASK_WRITE},  8'h00}, TYPED, '{1'b1, 8'h00}},
      '{'{ITEM_CMD, {OPC_REQUEST, REQ_MASK_READ},   8'h00}, TYPED, '{1'b1, 8'hF0}},
      '{'{ITEM_CMD, {OPC_REQUEST, 4'h2},            8'h00}, TYPED, '{1'b1, 8'hF0}},
      '{'{ITEM_CMD, {OPC_UNUSED, 4'hA},             8'h00}, TYPED, '{1'b0, 8'hF0}},
      '{'{ITEM_CMD, {OPC_POINTER, ARG_ADIN},        8'h00}, TYPED, '{1'b0, 8'hF0}},
      '{'{ITEM_CMD, {OPC_ACTION, ACT_POP},          8'h00}, TYPED, '{1'b1, 8'h00}},
      '{'{ITEM_TICK, 8'hFF,                         8'hFF}, TYPED, '{1'b0, 8'h00}},
      '{'{ITEM_CMD, {OPC_ACTION, ACT_TIME_READ},    8'h00}, PREDICTED, '{1'b0, 8'h00}},
      '{'{ITEM_CMD, {OPC_ACTION, ACT_POP},          8'h00}, PREDICTED, '{1'b0, 8'h00}},
      '{'{ITEM_CMD, {OPC_ACTION, ACT_TIME_WRITE},   8'h00}, PREDICTED, '{1'b0, 8'h00}},
      '{'{ITEM_CMD, {OPC_ACTION, ACT_PW_SET},       8'h00}, PREDICTED, '{1'b0, 8'h00}},
      '{'{ITEM_CMD, {OPC_REQUEST, REQ_STATUS},      8'h00}, TYPED,
        '{1'b1, STATUS_BASE | STATUS_PW_FLAG}},
      '{'{ITEM_CMD, {OPC_ACTION, ACT_PW_CLEAR},     8'h00}, PREDICTED, '{1'b0, 8'h00}}
   };

   // Clock, reset and the three channels. Every input starts at a known value.
   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_payload_type        req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_MAIN_SUPPLY;
   logic [7:0]             csr_data  = 8'h00;

   // Local copy of the block's state, advanced once per accepted request beat.
   logic [7:0]   stack_bytes [DEPTH]  = '{default: 8'h00};
   int           stack_top            = 0;
   logic [7:0]   secret      [PW_LEN] = '{default: 8'h00};
   logic [7:0]   mask_copy            = 8'h00;
   logic [7:0]   held_reply           = 8'h00;
   logic [7:0]   main_level           = LEVEL_RESET;
   logic [7:0]   aux_level            = LEVEL_RESET;
   calendar_type cal = '{sec: 8'h00, min: 8'h00, hour: 8'h00, day: DAY_FIRST,
                         month: MONTH_FIRST, weekday: 3'd0};

   // Replies still owed by the block, oldest first.
   rsp_payload_type pending_replies [$];

   int beats_sent  = 0;
   int fail_count  = 0;
   int cycle_count = 0;
   // While set, neither side of the bench inserts idle cycles.
   bit steady      = 1'b0;

   clock_command_coprocessor #(
      .STACK_DEPTH(DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Model of the block
   // ---------------------------------------------------------------------

   // One BCD step of a seconds or minutes pair; wrap is set when the pair
   // rolls over to zero and the next pair has to advance.
   function automatic bcd_step_type roll_pair(input logic [7:0] v, input logic [7:0] limit);
      bcd_step_type s;
      logic [7:0]   x;
      x       = v + 8'd1;
      s.wrap  = 1'b0;
      s.value = x;
      if (x[3:0] > 4'd9) begin
         x = {x[7:4] + 4'd1, 4'h0};
         if (x < limit) begin
            s.value = x;
         end else begin
            s.value = 8'h00;
            s.wrap  = 1'b1;
         end
      end
      return s;
   endfunction

   // Day rollover. Months outside 1 to 12 never end, so the day just counts.
   function automatic void next_calendar_day();
      logic [7:0] end_day;
      cal.day = cal.day + 8'd1;
      if (cal.day[3:0] > 4'd9) begin
         cal.day = {cal.day[7:4] + 4'd1, 4'h0};
      end
      cal.weekday = (cal.weekday == WEEKDAY_LAST) ? 3'd0 : cal.weekday + 3'd1;
      case (cal.month)
         8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: end_day = LONG_MONTH_END;
         8'd2, 8'd4, 8'd6, 8'd9, 8'd11:              end_day = SHORT_MONTH_END;
         default:                                    end_day = 8'h00;
      endcase
      if (end_day != 8'h00 && cal.day == end_day) begin
         cal.day   = DAY_FIRST;
         cal.month = (cal.month + 8'd1 == MONTH_WRAP) ? MONTH_FIRST : cal.month + 8'd1;
      end
   endfunction

   function automatic void tick_second();
      bcd_step_type s;
      logic [7:0]   h;
      s       = roll_pair(cal.sec, SEC_LIMIT);
      cal.sec = s.value;
      if (!s.wrap) return;
      s       = roll_pair(cal.min, SEC_LIMIT);
      cal.min = s.value;
      if (!s.wrap) return;
      h = cal.hour + 8'd1;
      if (h[3:0] > 4'd9) begin
         h = {h[7:4] + 4'd1, 4'h0};
      end
      if (h >= HOUR_LIMIT) begin
         cal.hour = 8'h00;
         next_calendar_day();
      end else begin
         cal.hour = h;
      end
   endfunction

   function automatic void push_stack(input logic [7:0] v);
      stack_bytes[stack_top] = v;
      stack_top              = (stack_top + 1) % DEPTH;
   endfunction

   // A time write takes a BCD pair from two stack entries unless either of
   // them holds the skip mark.
   function automatic bit pair_usable(input int hi);
      return stack_bytes[hi] != SKIP_MARK && stack_bytes[hi + 1] != SKIP_MARK;
   endfunction

   function automatic logic [7:0] stack_pair(input int hi);
      return {stack_bytes[hi][3:0], stack_bytes[hi + 1][3:0]};
   endfunction

   // Applies one request beat to the local state and returns its result beat.
   function automatic rsp_payload_type execute_beat(input req_payload_type b);
      logic [3:0] opc;
      logic [3:0] arg;
      logic       answered;
      bit         equal;
      opc      = b.cmd_byte[7:4];
      arg      = b.cmd_byte[3:0];
      answered = 1'b0;
      if (b.op == ITEM_TICK) begin
         tick_second();
      end else begin
         case (opc)
            OPC_PUSH_FROM_BASE: begin
               stack_top = 0;
               push_stack(8'h0F - {4'h0, arg});
            end
            OPC_PUSH: push_stack(8'h0F - {4'h0, arg});
            OPC_POINTER: begin
               if (arg == ARG_ADIN) stack_top = CONVERTER_PTR % DEPTH;
            end
            OPC_REQUEST: begin
               // Every request answers; unknown ones repeat the last reply.
               answered = 1'b1;
               case (arg)
                  REQ_STATUS_A, REQ_STATUS_B, REQ_INT_CAUSE: held_reply = 8'h00;
                  REQ_AUX_BATTERY: held_reply = aux_level;
                  REQ_ANALOG:      held_reply = b.analog_value;
                  REQ_MAIN_SUPPLY: held_reply = main_level;
                  REQ_ID:          held_reply = REPLY_ID;
                  REQ_STATUS: begin
                     held_reply = STATUS_BASE | ((secret[0] != 8'h00) ? STATUS_PW_FLAG : 8'h00);
                  end
                  REQ_MASK_READ:   held_reply = mask_copy;
                  REQ_MASK_WRITE:  mask_copy = {stack_bytes[0][3:0], 4'h0} + stack_bytes[1];
                  default: ;
               endcase
            end
            OPC_ACTION: begin
               case (arg)
                  ACT_PW_CLEAR: begin
                     equal = 1'b1;
                     for (int k = 0; k < PW_LEN; k++) begin
                        if (secret[k] != stack_bytes[k]) equal = 1'b0;
                     end
                     if (equal) secret[0] = 8'h00;
                  end
                  ACT_PW_SET: begin
                     for (int k = 0; k < PW_LEN; k++) secret[k] = stack_bytes[k];
                  end
                  ACT_TIME_READ: begin
                     stack_top = 0;
                     push_stack(cal.month);
                     push_stack({4'h0, cal.day[7:4]});
                     push_stack({4'h0, cal.day[3:0]});
                     push_stack({4'h0, cal.hour[7:4]});
                     push_stack({4'h0, cal.hour[3:0]});
                     push_stack({4'h0, cal.min[7:4]});
                     push_stack({4'h0, cal.min[3:0]});
                     push_stack({4'h0, cal.sec[7:4]});
                     push_stack({4'h0, cal.sec[3:0]});
                     stack_top = 0;
                  end
                  ACT_TIME_WRITE: begin
                     if (stack_bytes[0] != SKIP_MARK) cal.month = stack_bytes[0];
                     if (pair_usable(1)) cal.day  = stack_pair(1);
                     if (pair_usable(3)) cal.hour = stack_pair(3);
                     if (pair_usable(5)) cal.min  = stack_pair(5);
                     if (pair_usable(7)) cal.sec  = stack_pair(7);
                  end
                  ACT_POP: begin
                     held_reply = stack_bytes[stack_top];
                     stack_top  = (stack_top + 1) % DEPTH;
                     answered   = 1'b1;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
      return '{reply_valid: answered, reply_byte: held_reply};
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Puts one request beat on the input channel, with a random gap in front
   // of it, and records the expected reply once the beat is accepted. Valid
   // stays high from one beat to the next when there is no gap, so back to
   // back beats never see a low pulse.
   task automatic send_beat(input req_payload_type beat);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_replies.push_back(execute_beat(beat));
      beats_sent++;
      steady = (beats_sent >= 260 && beats_sent < 400);
   endtask

   function automatic req_payload_type command_beat(input logic [3:0] opc, input logic [3:0] arg);
      return '{op: ITEM_CMD, cmd_byte: {opc, arg}, analog_value: 8'($urandom_range(255))};
   endfunction

   // Pushes the byte v (0 to 15); the base form first resets the pointer.
   task automatic push_nibble(input logic [3:0] v, input bit at_base);
      send_beat(command_beat(at_base ? OPC_PUSH_FROM_BASE : OPC_PUSH, 4'hF - v));
   endtask

   // Digit pair for a time load: mostly a value just below its wrap, else
   // random digits or a skip mark in one of the two places.
   function automatic logic [7:0] clock_pair(input logic [7:0] hot);
      int r;
      r = $urandom_range(9);
      if (r < 6) return hot;
      if (r < 8) return {4'($urandom_range(15)), 4'($urandom_range(15))};
      if (r == 8) return {SKIP_MARK[3:0], 4'($urandom_range(15))};
      return {4'($urandom_range(15)), SKIP_MARK[3:0]};
   endfunction

   // Configuration is written only with the block drained: request valid
   // is dropped first, then every owed reply has to come back.
   task automatic apply_levels(input logic [7:0] main_value, input logic [7:0] aux_value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_MAIN_SUPPLY;
      csr_data  <= main_value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      main_level = main_value;
      @(negedge clock);
      csr_index <= CSR_AUX_BATTERY;
      csr_data  <= aux_value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      aux_level = aux_value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random command sequences until the beat count reaches target. Most of
   // them are well-formed: time loads followed by ticks and a read back,
   // password set and clear, mask writes and pointer walks. The rest are
   // runs of one to four requests and raw noise.
   task automatic run_traffic(input int target);
      int         pick;
      int         r;
      logic [7:0] hot [4];
      logic [7:0] digits;
      while (beats_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            // Time load close to the end of a minute, hour, day and month,
            // then enough ticks to cross some of those boundaries.
            r = $urandom_range(9);
            if (r < 7) begin
               push_nibble(4'($urandom_range(1, 12)), 1'b1);
            end else if (r < 8) begin
               push_nibble(4'd12, 1'b1);
            end else begin
               push_nibble(4'($urandom_range(15)), 1'b1);
            end
            hot[0] = $urandom_range(1) ? 8'h31 : 8'h30;
            hot[1] = 8'h23;
            hot[2] = 8'h59;
            hot[3] = {4'h5, 4'($urandom_range(5, 9))};
            for (int k = 0; k < 4; k++) begin
               digits = clock_pair(hot[k]);
               push_nibble(digits[7:4], 1'b0);
               push_nibble(digits[3:0], 1'b0);
            end
            send_beat(command_beat(OPC_ACTION, ACT_TIME_WRITE));
            repeat ($urandom_range(1, 12)) begin
               send_beat('{op: ITEM_TICK, cmd_byte: 8'($urandom_range(255)),
                           analog_value: 8'($urandom_range(255))});
            end
            send_beat(command_beat(OPC_ACTION, ACT_TIME_READ));
            repeat (9) send_beat(command_beat(OPC_ACTION, ACT_POP));
         end else if (pick < 40) begin
            // Password set from a fresh stack, then a clear that matches
            // unless the bottom byte has been pushed over in between.
            push_nibble(4'($urandom_range(15)), 1'b1);
            repeat (PW_LEN - 1) push_nibble(4'($urandom_range(15)), 1'b0);
            send_beat(command_beat(OPC_ACTION, ACT_PW_SET));
            send_beat(command_beat(OPC_REQUEST, REQ_STATUS));
            if ($urandom_range(2) == 0) push_nibble(4'($urandom_range(15)), 1'b1);
            send_beat(command_beat(OPC_ACTION, ACT_PW_CLEAR));
            send_beat(command_beat(OPC_REQUEST, REQ_STATUS));
         end else if (pick < 52) begin
            push_nibble(4'($urandom_range(15)), 1'b1);
            push_nibble(4'($urandom_range(15)), 1'b0);
            send_beat(command_beat(OPC_REQUEST, REQ_MASK_WRITE));
            send_beat(command_beat(OPC_REQUEST, REQ_MASK_READ));
         end else if (pick < 66) begin
            // Pointer walk; a run of pops from the converter address carries
            // the pointer through its wrap back to zero.
            if ($urandom_range(1)) begin
               send_beat(command_beat(OPC_POINTER, ARG_ADIN));
            end else begin
               push_nibble(4'($urandom_range(15)), 1'b1);
            end
            if ($urandom_range(3) == 0) begin
               repeat (40) send_beat(command_beat(OPC_ACTION, ACT_POP));
            end else begin
               repeat ($urandom_range(1, 20)) begin
                  if ($urandom_range(1)) begin
                     send_beat(command_beat(OPC_ACTION, ACT_POP));
                  end else begin
                     push_nibble(4'($urandom_range(15)), 1'b0);
                  end
               end
            end
         end else if (pick < 88) begin
            repeat ($urandom_range(1, 4)) begin
               send_beat(command_beat(OPC_REQUEST, 4'($urandom_range(15))));
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_beat('{op: 1'($urandom_range(1)), cmd_byte: 8'($urandom_range(255)),
                           analog_value: 8'($urandom_range(255))});
            end
         end
      end
   endtask

   // The result side stalls on its own schedule, except in the steady window.
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 8);
   end

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   function automatic void report_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("mismatch: %s", msg);
   endfunction

   // Result beats are sampled at the rising edge and matched in order
   // against the replies the model has queued.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            report_failure($sformatf("result beat %h with no reply owed", rsp_data));
         end else begin
            want = pending_replies.pop_front();
            if (rsp_data.reply_valid !== want.reply_valid) begin
               report_failure($sformatf("reply_valid expected %b, got %b",
                                        want.reply_valid, rsp_data.reply_valid));
            end
            if (rsp_data.reply_byte !== want.reply_byte) begin
               report_failure($sformatf("reply_byte expected %h, got %h",
                                        want.reply_byte, rsp_data.reply_byte));
            end
         end
      end
   end

   // Hard stop in case a handshake never completes.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed table. A row with a written-out reply replaces the model's
      // expectation for that beat; the model still advances on every row.
      for (int i = 0; i < $size(DIRECTED); i++) begin
         send_beat(DIRECTED[i].beat);
         if (DIRECTED[i].typed) begin
            pending_replies[pending_replies.size() - 1] = DIRECTED[i].reply;
         end
      end

      // Random phases, each under its own pair of supply levels, the
      // extremes first.
      apply_levels(8'h00, 8'hFF);
      run_traffic(beats_sent + 125);
      apply_levels(8'hFF, 8'h00);
      run_traffic(beats_sent + 125);
      apply_levels(8'($urandom_range(255)), 8'($urandom_range(255)));
      run_traffic(beats_sent + 125);
      apply_levels(LEVEL_RESET, 8'($urandom_range(255)));
      run_traffic(beats_sent + 125);

      // Drain: drop valid, wait for every owed reply, then a short tail to
      // catch any stray result beat.
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (pending_replies.size() != 0) begin
         report_failure($sformatf("%0d replies never arrived", pending_replies.size()));
      end

      if (fail_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
